// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // queued item from the front to the back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Accepts input items, drops empty ones and queues the rest for the core.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sha_pkg::item_t in_item_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output sha_pkg::item_t     q_item_o
);
  import sha_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t         mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          push, pop, useful;

  // items with neither a byte nor an end are consumed without queueing
  assign useful     = in_item_i.byte_present | in_item_i.end_of_message;
  assign in_ready_o = (cnt_q != (AW+1)'(Depth));
  assign push       = in_valid_i & in_ready_o & useful;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue overflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Block buffer, padding sequencer, one-round-per-cycle compression and
// digest output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_ready_o,
  input  wire sha_pkg::item_t q_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [63:0]         digest_part_o,
  output logic [1:0]          part_index_o,
  output logic                last_part_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_COMP, S_ADD, S_OUT
  } state_e;

  state_e      state_q, ret_q;
  logic [5:0]  fill_q;
  logic [63:0] bits_q, len_q;
  logic [2:0]  len_idx_q;
  logic        ending_q;
  logic [5:0]  rnd_q;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [1:0]  part_q;
  word_t       buf_q [16];
  logic [7:0]  wbyte;
  logic        wen;
  logic        mark_q;
  word_t       s0, s1, wnew, wcur, t1, t2;

  assign q_ready_o = (state_q == S_IDLE);

  // byte written into the block buffer this cycle
  always_comb begin
    wen   = 1'b0;
    wbyte = q_item_i.data_byte;
    unique case (state_q)
      S_IDLE: wen = q_valid_i & q_item_i.byte_present;
      S_PAD: begin
        wen   = 1'b1;
        wbyte = mark_q ? PadByte : '0;
      end
      S_LEN: begin
        wen   = 1'b1;
        wbyte = len_q[{~len_idx_q, 3'b000} +: 8];
      end
      default: wen = 1'b0;
    endcase
  end

  // schedule and round datapath
  assign wcur = (rnd_q < 6'd16) ? buf_q[rnd_q[3:0]] : w_q[15];
  assign s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign t1   = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
              + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q)
              + ((rnd_q < 6'd16) ? wcur : wnew);
  assign t2   = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
              + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // block buffer, sixteen big-endian words filled a byte lane at a time
  always_ff @(posedge clk_i) begin
    if (wen) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wbyte;
  end

  // working registers and schedule window
  always_ff @(posedge clk_i) begin
    if (state_q == S_COMP) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= (rnd_q < 6'd16) ? wcur : wnew;
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  // sequencer with state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      fill_q    <= '0;
      bits_q    <= '0;
      len_q     <= '0;
      len_idx_q <= '0;
      ending_q  <= 1'b0;
      rnd_q     <= '0;
      part_q    <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_item_i.byte_present) begin
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 1'b1;
            end
            ending_q <= q_item_i.end_of_message;
            len_q    <= bits_q + (q_item_i.byte_present ? 64'd8 : 64'd0);
            if (q_item_i.byte_present && fill_q == 6'd63) begin
              state_q <= S_COMP;
              ret_q   <= q_item_i.end_of_message ? S_PAD : S_IDLE;
              rnd_q   <= '0;
            end else if (q_item_i.end_of_message) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // 0x80 marker is written by overriding the first pad byte
          fill_q <= fill_q + 1'b1;
          if (fill_q == 6'd63) begin
            state_q <= S_COMP;
            ret_q   <= S_PAD;
            rnd_q   <= '0;
          end else if (fill_q + 1'b1 == LenPos) begin
            state_q   <= S_LEN;
            len_idx_q <= '0;
          end
        end
        S_LEN: begin
          fill_q    <= fill_q + 1'b1;
          len_idx_q <= len_idx_q + 1'b1;
          if (len_idx_q == 3'd7) begin
            state_q <= S_COMP;
            ret_q   <= S_OUT;
            rnd_q   <= '0;
          end
        end
        S_COMP: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) state_q <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          state_q <= ret_q;
          part_q  <= '0;
        end
        default: begin
          if (out_ready_i) begin
            part_q <= part_q + 1'b1;
            if (part_q == 2'd3) begin
              state_q  <= S_IDLE;
              bits_q   <= '0;
              ending_q <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
            end
          end
        end
      endcase
    end
  end

  // marker byte: first pad write after the end item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (state_q == S_IDLE && q_valid_i && q_item_i.end_of_message) begin
      mark_q <= 1'b1;
    end else if (state_q == S_PAD) begin
      mark_q <= 1'b0;
    end
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign digest_part_o = {h_q[{part_q, 1'b0}], h_q[{part_q, 1'b1}]};
  assign part_index_o  = part_q;
  assign last_part_o   = (part_q == 2'd3);

`ifndef SYNTHESIS
  a_out_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ending_q) else $error("digest without end");
  a_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> $past(rnd_q) == 6'd63) else $error("round count");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(part_q)) else $error("part moved");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// End of message: with the core idle, an end item is followed by the padding bytes, then
// one or two 64-round compressions and a final add, before its first digest part.
// Throughput: one byte per cycle into the block buffer while the core is idle; each full
// block then holds the single round unit, and the core takes no byte until it is done.
// Digest parts are given one per cycle while the sink is ready.
// Reset: asynchronous active low; hash state returns to the initial value.
`default_nettype none
module sha256_byte_stream_hasher #(
  parameter int unsigned QDepth = sha_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tuser,  // byte_present
  input  wire logic        s_axis_tlast,  // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // digest_part
  output logic [1:0]       m_axis_tuser,  // part_index
  output logic             m_axis_tlast   // last_part
);
  import sha_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                     end_of_message: s_axis_tlast};

  sha_front #(.Depth(QDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .digest_part_o(m_axis_tdata), .part_index_o(m_axis_tuser),
    .last_part_o(m_axis_tlast)
  );
endmodule
`default_nettype wire

// ===== sim/tb_sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// Streams random and directed messages into the hasher, predicts each digest
// with a local SHA-256 model and checks every digest part in order.
// ----------------------------------------------------------------------------
`default_nettype none

// expected digest parts and mismatch bookkeeping
class digest_scoreboard;
  logic [31:0] hash_h[8];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [63:0] msg_bits;
  logic [63:0] exp_part[$];
  logic [1:0]  exp_idx[$];
  logic        exp_last[$];
  int unsigned errors;

  function new();
    restart();
    errors = 0;
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::init_h(i[2:0]);
    fill = 0;
    msg_bits = '0;
  endfunction

  function logic [31:0] rot(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(i[5:0]) + w[i];
      t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function void push_byte(logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  // note an accepted input item
  function void note_item(logic [7:0] data, logic present, logic eom);
    logic [63:0] len;
    if (present) begin
      msg_bits += 64'd8;
      push_byte(data);
    end
    if (!eom) return;
    len = msg_bits;
    push_byte(8'h80);
    while (fill != 56) push_byte(8'h00);
    for (int k = 0; k < 8; k++) push_byte(len[63-8*k -: 8]);
    for (int k = 0; k < 4; k++) begin
      exp_part.insert(exp_part.size(), {hash_h[2*k], hash_h[2*k+1]});
      exp_idx.insert(exp_idx.size(), k[1:0]);
      exp_last.insert(exp_last.size(), (k == 3));
    end
    restart();
  endfunction

  // compare one digest part with the oldest expectation
  function void check_part(logic [63:0] part, logic [1:0] idx, logic last);
    logic [63:0] ep;
    logic [1:0]  ei;
    logic        el;
    if (exp_part.size() == 0) begin
      if (errors < 10) $display("unexpected digest part %h idx %0d", part, idx);
      errors++;
      return;
    end
    ep = exp_part.pop_front();
    ei = exp_idx.pop_front();
    el = exp_last.pop_front();
    if (part !== ep || idx !== ei || last !== el) begin
      if (errors < 10)
        $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                 ep, ei, el, part, idx, last);
      errors++;
    end
  endfunction
endclass

module tb_sha256_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tuser = 1'b0; // byte_present
  logic        s_axis_tlast = 1'b0; // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // digest_part
  logic [1:0]  m_axis_tuser;        // part_index
  logic        m_axis_tlast;        // last_part

  digest_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;

  sha256_byte_stream_hasher u_top (.*);

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern and result checking
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_part(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (rst_ni) begin
      if (cycles[9:8] == 2'd1) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // send one item after the given gap (random from next_gap, none while a burst runs)
  task automatic send_item(logic [7:0] data, logic present, logic eom, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(data, present, eom);
    sent++;
  endtask

  int burst = 0;
  function automatic int next_gap();
    if (burst > 0) begin
      burst--;
      return 0;
    end
    burst = $urandom_range(0, 20);
    return $urandom_range(0, 6);
  endfunction

  // random message of the given length, with some empty items mixed in
  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, next_gap());
      send_item(8'($urandom), 1'b1, (i == len - 1), next_gap());
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1, next_gap());
  endtask

  // stop sending and wait for every expected digest part
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_part.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, end without byte after bytes, all-ones and zero bytes
    send_item(8'h00, 1'b0, 1'b1, 0);
    send_item(8'hff, 1'b0, 1'b0, 0);
    send_item(8'hff, 1'b1, 1'b0, 0);
    send_item(8'h00, 1'b1, 1'b0, 0);
    send_item(8'h5a, 1'b0, 1'b1, 0);
    send_item(8'hff, 1'b1, 1'b1, 0);
    send_item(8'h00, 1'b1, 1'b1, 0);
    drain();

    // lengths around the padding boundaries, then random sizes
    send_message(55);
    send_message(56);
    drain();
    send_message(64);
    while (sent < 460) begin
      send_message($urandom_range(0, 9) == 0 ? $urandom_range(50, 70)
                                             : $urandom_range(0, 20));
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_part.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_core.sv
rtl/core/sha256_byte_stream_hasher.sv
sim/tb_sha256_byte_stream_hasher.sv
